[rtl/core/smt_pkg.sv]
// smt_pkg: types and constants shared by the sorted multiset table.
// Used by smt_ctrl, smt_datapath and sorted_multiset_table; no dependencies.
package smt_pkg;

  localparam int VAL_W = 32;
  localparam int OCC_W = 6;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_COUNT  = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;

  // Status codes
  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] payload;
    logic                    is_last;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic ins;    // insert request value, load status result
    logic del;    // delete request value, load status result
    logic count;  // load count result, restart report walk
    logic step;   // rotate table by one slot
    logic emit;   // load head value as result (with step)
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;   // output register holds an untaken result
    logic occ_zero;
    logic last_step;  // report walk at final slot
    logic run_end;    // head is the last of its run of equal values
  } sts_t;

endpackage

[rtl/core/smt_datapath.sv]
// smt_datapath: table cells with parallel compare and shift, occupancy,
// report walk counter and the output result register. Depends on smt_pkg.
module smt_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  smt_pkg::in_t  in_data,
  input  smt_pkg::cmd_t cmd,
  input  logic          out_ready,
  output smt_pkg::sts_t sts,
  output logic          out_valid,
  output smt_pkg::out_t out_data
);
  import smt_pkg::*;

  logic signed [VAL_W-1:0] cell_r   [CAPACITY];
  logic signed [VAL_W-1:0] cell_nxt [CAPACITY];
  logic signed [VAL_W-1:0] above    [CAPACITY];
  logic signed [VAL_W-1:0] below    [CAPACITY];
  logic [CAPACITY-1:0]     keep;
  logic [CAPACITY-1:0]     below_keep;
  logic [CAPACITY-1:0]     ge;
  logic [CAPACITY-1:0]     match;

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [OCC_W-1:0] occ_m1;
  logic [OCC_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  logic             full;
  logic             found;
  logic             last_step;

  assign occ_m1    = occ_r - OCC_W'(1);
  assign full      = (occ_r == OCC_W'(CAPACITY));
  assign found     = |match;
  assign last_step = (idx_r == occ_m1);

  genvar k;
  generate
    for (k = 0; k < CAPACITY; k++) begin : g_cell
      logic in_use;
      assign in_use   = (OCC_W'(k) < occ_r);
      assign keep[k]  = in_use && (cell_r[k] <= in_data.value);
      assign ge[k]    = in_use && (cell_r[k] >= in_data.value);
      assign match[k] = in_use && (cell_r[k] == in_data.value);

      if (k == 0) begin : g_first
        assign below[k]      = in_data.value;
        assign below_keep[k] = 1'b1;
      end else begin : g_rest
        assign below[k]      = cell_r[k-1];
        assign below_keep[k] = keep[k-1];
      end

      if (k + 1 < CAPACITY) begin : g_up
        assign above[k] = cell_r[k+1];
      end else begin : g_top
        assign above[k] = cell_r[k];
      end

      always_comb begin
        cell_nxt[k] = cell_r[k];
        if (cmd.ins && !full) begin
          // cells holding values <= v stay; the first other slot takes v
          if (!keep[k]) begin
            cell_nxt[k] = below_keep[k] ? in_data.value : below[k];
          end
        end else if (cmd.del && found) begin
          // first match is the first cell >= v; everything from it moves down
          if (ge[k]) begin
            cell_nxt[k] = above[k];
          end
        end else if (cmd.step) begin
          // rotate slots 0..occ-1 toward the head
          if (OCC_W'(k) < occ_m1) begin
            cell_nxt[k] = above[k];
          end else if (OCC_W'(k) == occ_m1) begin
            cell_nxt[k] = cell_r[0];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.ins && !full) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (cmd.del && found) begin
      occ_nxt = occ_m1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.count) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + OCC_W'(1);
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.ins) begin
      out_nxt.kind    = KIND_STATUS;
      out_nxt.status  = full ? STS_FULL : STS_DONE;
      out_nxt.payload = '0;
      out_nxt.is_last = 1'b1;
      out_valid_nxt   = 1'b1;
    end else if (cmd.del) begin
      out_nxt.kind    = KIND_STATUS;
      out_nxt.status  = found ? STS_DONE : STS_NOT_FOUND;
      out_nxt.payload = '0;
      out_nxt.is_last = 1'b1;
      out_valid_nxt   = 1'b1;
    end else if (cmd.count) begin
      out_nxt.kind    = KIND_COUNT;
      out_nxt.status  = STS_DONE;
      out_nxt.payload = $signed({{(VAL_W-OCC_W){1'b0}}, occ_r});
      out_nxt.is_last = (occ_r == '0);
      out_valid_nxt   = 1'b1;
    end else if (cmd.emit) begin
      out_nxt.kind    = KIND_VALUE;
      out_nxt.status  = STS_DONE;
      out_nxt.payload = cell_r[0];
      out_nxt.is_last = last_step;
      out_valid_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign sts.out_busy  = out_valid_r;
  assign sts.occ_zero  = (occ_r == '0);
  assign sts.last_step = last_step;
  assign sts.run_end   = last_step || (cell_r[0] != above[0]);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins && !full) |=> (occ_r == $past(occ_r) + OCC_W'(1)))
    else $error("insert did not grow occupancy");
`endif

endmodule

[rtl/core/smt_ctrl.sv]
// smt_ctrl: request sequencing for the sorted multiset table; drives
// datapath commands from the input handshake. Depends on smt_pkg.
module smt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  input  logic          out_ready,
  input  smt_pkg::sts_t sts,
  output logic          in_ready,
  output smt_pkg::cmd_t cmd
);
  import smt_pkg::*;

  state_t state_r, state_nxt;
  logic   slot_free;
  logic   accept;

  assign slot_free = !sts.out_busy || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_REPORT) && !sts.occ_zero) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (cmd.step && sts.last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          unique case (in_op)
            OP_INSERT: cmd.ins   = 1'b1;
            OP_DELETE: cmd.del   = 1'b1;
            OP_REPORT: cmd.count = 1'b1;
            default:   ;  // unused code: dropped
          endcase
        end
      end
      ST_REPORT: begin
        // only the last slot of each run of equal values produces a result
        cmd.step = !sts.run_end || slot_free;
        cmd.emit = sts.run_end && slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPORT) |-> !in_ready)
    else $error("request accepted during report");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ins, cmd.del, cmd.count, cmd.emit}))
    else $error("more than one result load");
`endif

endmodule

[rtl/core/sorted_multiset_table.sv]
// Sorted multiset table: a bounded table of signed 32-bit values kept in
// ascending order, duplicates allowed.
// Requests arrive on in_valid/in_ready with in_data (operation, value);
// results leave on out_valid/out_ready with out_data (kind, status,
// payload, is_last). Insert and delete finish in the cycle of acceptance
// with one status result in the next cycle; one such request per cycle
// while results are taken. Insert places the value after equal values;
// delete removes the first occurrence. A report gives the count in the
// cycle after acceptance, then walks the table by rotating it one slot a
// cycle while the receiver keeps up, giving each distinct value in
// ascending order. No request is taken during a report walk.
// A stalled receiver holds the output register; new requests wait until
// it is free. Reset empties the table at once (no clearing pass); the
// stored values themselves are not reset. Unused operation code 3 is
// accepted and produces no result.
// Depends on smt_pkg, smt_ctrl and smt_datapath.
module sorted_multiset_table #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  smt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output smt_pkg::out_t out_data
);
  import smt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  smt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[dv/tb_sorted_multiset_table.sv]
// Self-checking testbench for sorted_multiset_table: a predicting scoreboard
// class, request/result drivers with random stalls, directed and random traffic.
// Depends on smt_pkg and the sorted_multiset_table RTL.
`timescale 1ns / 1ps

module tb_sorted_multiset_table;
  import smt_pkg::*;

  localparam int TABLE_DEPTH    = 32;
  localparam int RANDOM_ITEMS   = 212;
  localparam int QUIET_STRETCH  = 40;
  localparam int TAIL_CYCLES    = TABLE_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // Tracks the table contents and the results each request should produce.
  class multiset_scoreboard;
    logic signed [VAL_W-1:0] sorted_vals[$];
    out_t expected_q[$];
    int errors = 0;

    function void push_result(logic [1:0] kind, logic [1:0] status,
                              logic signed [VAL_W-1:0] payload, logic is_last);
      out_t r;
      r.kind    = kind;
      r.status  = status;
      r.payload = payload;
      r.is_last = is_last;
      expected_q.push_back(r);
    endfunction

    function void note_request(in_t req);
      logic signed [VAL_W-1:0] v;
      int pos;
      v   = req.value;
      pos = 0;
      case (req.operation)
        OP_INSERT: begin
          if (sorted_vals.size() >= TABLE_DEPTH) begin
            push_result(KIND_STATUS, STS_FULL, '0, 1'b1);
          end else begin
            // lands after any equal values
            while (pos < sorted_vals.size() && sorted_vals[pos] <= v) pos++;
            sorted_vals.insert(pos, v);
            push_result(KIND_STATUS, STS_DONE, '0, 1'b1);
          end
        end
        OP_DELETE: begin
          while (pos < sorted_vals.size() && sorted_vals[pos] != v) pos++;
          if (pos == sorted_vals.size()) begin
            push_result(KIND_STATUS, STS_NOT_FOUND, '0, 1'b1);
          end else begin
            sorted_vals.delete(pos);
            push_result(KIND_STATUS, STS_DONE, '0, 1'b1);
          end
        end
        OP_REPORT: begin
          push_result(KIND_COUNT, STS_DONE, VAL_W'(sorted_vals.size()),
                      sorted_vals.size() == 0);
          foreach (sorted_vals[i])
            if (i == 0 || sorted_vals[i] != sorted_vals[i-1])
              push_result(KIND_VALUE, STS_DONE, sorted_vals[i],
                          sorted_vals[i] == sorted_vals[$]);
        end
        default: ;  // code 3: no result, no change
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d status %0d payload %0d is_last %0d",
               got.kind, got.status, got.payload, got.is_last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.payload !== want.payload) begin
        $error("payload: expected %0d, got %0d", want.payload, got.payload);
        errors++;
      end
      if (got.is_last !== want.is_last) begin
        $error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int occupancy();
      return sorted_vals.size();
    endfunction

    function logic signed [VAL_W-1:0] pick_stored();
      return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
    endfunction
  endclass

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  in_t   in_data   = '0;
  logic  out_ready = 1'b0;
  logic  in_ready;
  logic  out_valid;
  out_t  out_data;

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int n_items      = 0;
  int quiet_cycles = 0;
  multiset_scoreboard sb;

  sorted_multiset_table #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Handshakes are sampled mid-cycle, where everything driven at the edge is settled.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid === 1'b1 && in_ready === 1'b1) sb.note_request(in_data);
      if (out_valid === 1'b1 && out_ready === 1'b1) sb.check_result(out_data);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Entered and left at a rising edge; returns on the edge that takes the request.
  task automatic send_request(input logic [1:0] op, input logic signed [VAL_W-1:0] v);
    in_t req;
    req.operation = op;
    req.value     = v;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
    if (op != OP_UNUSED) n_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return VAL_W'($urandom_range(0, 6)) - 3;  // dense, lots of duplicates
      1: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_op();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      send_request(OP_INSERT, pick_value());
    else if (pick < 75)
      send_request(OP_DELETE, (sb.occupancy() > 0 && $urandom_range(0, 9) < 7) ?
                   sb.pick_stored() : pick_value());
    else if (pick < 95)
      send_request(OP_REPORT, $urandom());
    else
      send_request(OP_UNUSED, $urandom());
  endtask

  task automatic fill_table();
    while (sb.occupancy() < TABLE_DEPTH) send_request(OP_INSERT, pick_value());
    repeat ($urandom_range(1, 3)) send_request(OP_INSERT, pick_value());
    send_request(OP_REPORT, $urandom());
  endtask

  task automatic empty_table();
    while (sb.occupancy() > 0) send_request(OP_DELETE, sb.pick_stored());
    send_request(OP_REPORT, $urandom());
    send_request(OP_DELETE, pick_value());
  endtask

  task automatic run_directed();
    send_request(OP_REPORT, '0);           // empty report
    send_request(OP_DELETE, '0);           // miss on empty table
    send_request(OP_INSERT, 32'sd42);
    send_request(OP_DELETE, 32'sd42);      // removes the only entry
    send_request(OP_REPORT, '1);
    send_request(OP_INSERT, VAL_MIN);
    send_request(OP_INSERT, VAL_MAX);
    send_request(OP_INSERT, '0);
    send_request(OP_INSERT, '1);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_UNUSED, 32'h5a5a_a5a5);
    send_request(OP_REPORT, '0);
    send_request(OP_DELETE, 32'sd5);
    send_request(OP_DELETE, 32'sd7);       // miss on populated table
    send_request(OP_REPORT, '0);
    send_request(OP_DELETE, VAL_MIN);
    send_request(OP_DELETE, VAL_MAX);
    send_request(OP_REPORT, '0);
  endtask

  task automatic run_random();
    int stop_at;
    int n;
    bit quiet;
    stop_at = n_items + RANDOM_ITEMS;
    fill_table();
    empty_table();
    while (n_items < stop_at) begin
      quiet = (n_items >= stop_at - QUIET_STRETCH);
      if (quiet) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      case ($urandom_range(0, 9))
        0: fill_table();
        1: empty_table();
        2: begin
          if (!quiet) wait_drained();
        end
        3: begin
          if (!quiet) begin
            src_idle_en  = $urandom_range(0, 1);
            sink_idle_en = $urandom_range(0, 1);
          end
        end
        default: begin
          n = $urandom_range(1, 8);
          repeat (n) send_random_op();
        end
      endcase
    end
  endtask

  initial begin : stimulus
    sb = new();
    @(posedge clk iff rst_n);
    run_directed();
    wait_drained();
    run_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
rtl/core/smt_pkg.sv
rtl/core/smt_datapath.sv
rtl/core/smt_ctrl.sv
rtl/core/sorted_multiset_table.sv
dv/tb_sorted_multiset_table.sv
